// ===== hdl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Field widths and limits shared by the core, its frame store and checker.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int PAGE_FIELD_W = 16;
   localparam int SLOT_W       = 5;
   localparam int STAMP_W      = 32;
   localparam int COUNT_W      = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

// ===== hdl/lrupr_frame_store.sv =====
// ----------------------------------------------------------------------------
// LRU frame store
// Page tag and last-use stamp memories, one write port, one registered read.
// ----------------------------------------------------------------------------
module lrupr_frame_store #(
   parameter int NUM_FRAMES = 32,
   parameter int PAGE_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(NUM_FRAMES)-1:0]    wr_addr,
   input  logic [PAGE_BITS-1:0]             wr_page,
   input  logic [lrupr_pkg::STAMP_W-1:0]    wr_stamp,
   input  logic [$clog2(NUM_FRAMES)-1:0]    rd_addr,
   output logic [PAGE_BITS-1:0]             rd_page,
   output logic [lrupr_pkg::STAMP_W-1:0]    rd_stamp
);
   import lrupr_pkg::*;

   logic [PAGE_BITS-1:0] page_mem [NUM_FRAMES];
   logic [STAMP_W-1:0]   stamp_mem [NUM_FRAMES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_addr]  <= wr_page;
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      rd_page  <= page_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
   end

endmodule

// ===== hdl/lru_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement core
// Fully associative frame set: scan for hit, free frame and oldest stamp,
// then refresh, fill or replace one frame and report the outcome.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | page_number
//  rsp     | out       | rsp_valid/rsp_stall | hit, frame_slot, evicted_valid,
//          |           |                     | evicted_page, fault_total
//
//  A transaction reads the frame store once per frame through a single compare
//  unit, then waits in a tail state for the last read data, commits in a commit
//  state and returns to idle.
//  Synchronous reset empties every frame and clears use clock and fault count.
//  A stalled response holds the commit until the output register frees up.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
   parameter int NUM_FRAMES = 32,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lrupr_pkg::PAGE_FIELD_W-1:0]   req_page_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [lrupr_pkg::SLOT_W-1:0]         rsp_frame_slot,
   output logic                                 rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_FIELD_W-1:0]   rsp_evicted_page,
   output logic [lrupr_pkg::COUNT_W-1:0]        rsp_fault_total
);
   import lrupr_pkg::*;

   localparam int IDX_W   = $clog2(NUM_FRAMES);
   localparam int PEXT_W  = (PAGE_BITS > PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
   localparam int SEXT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_COMMIT
   } state_type;

   state_type             state_ff;
   logic [IDX_W-1:0]      cnt_ff;
   logic [IDX_W-1:0]      chk_idx_ff;
   logic                  chk_vld_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [NUM_FRAMES-1:0] frame_valid_ff;
   logic                  hit_found_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic [IDX_W-1:0]      lru_idx_ff;
   logic [STAMP_W-1:0]    lru_stamp_ff;
   logic [PAGE_BITS-1:0]  lru_page_ff;
   logic [STAMP_W-1:0]    use_clock_ff;
   logic [COUNT_W-1:0]    fault_count_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic                      rsp_evicted_ff;
   logic [PAGE_FIELD_W-1:0]   rsp_evicted_page_ff;
   logic [COUNT_W-1:0]        rsp_fault_total_ff;

   logic [PAGE_BITS-1:0]  rd_page;
   logic [STAMP_W-1:0]    rd_stamp;

   logic [PEXT_W-1:0]     req_page_ext;
   logic [PEXT_W-1:0]     lru_page_ext;
   logic [SEXT_W-1:0]     slot_ext;
   logic [PAGE_BITS-1:0]  page_in;

   logic                  scan_valid;
   logic                  scan_hit;
   logic                  scan_free;
   logic                  scan_lower;

   logic                  out_free;
   logic                  commit_go;
   logic                  evict_in;
   logic [IDX_W-1:0]      slot_in;
   logic [STAMP_W-1:0]    use_clock_in;
   logic [COUNT_W-1:0]    fault_count_in;

   lrupr_frame_store #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (commit_go),
      .wr_addr  (slot_in),
      .wr_page  (page_ff),
      .wr_stamp (use_clock_in),
      .rd_addr  (cnt_ff),
      .rd_page  (rd_page),
      .rd_stamp (rd_stamp)
   );

   assign req_page_ext = PEXT_W'(req_page_number);
   assign page_in      = req_page_ext[PAGE_BITS-1:0];
   assign lru_page_ext = PEXT_W'(lru_page_ff);

   assign scan_valid = frame_valid_ff[chk_idx_ff];
   assign scan_hit   = chk_vld_ff && scan_valid && !hit_found_ff && (rd_page == page_ff);
   assign scan_free  = chk_vld_ff && !scan_valid && !free_found_ff;
   assign scan_lower = chk_vld_ff && ((chk_idx_ff == '0) || (rd_stamp < lru_stamp_ff));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit_go = (state_ff == ST_COMMIT) && out_free;
   assign evict_in  = !hit_found_ff && !free_found_ff;

   always_comb begin
      priority if (hit_found_ff) begin
         slot_in = hit_idx_ff;
      end else if (free_found_ff) begin
         slot_in = free_idx_ff;
      end else begin
         slot_in = lru_idx_ff;
      end
   end

   assign slot_ext     = SEXT_W'(slot_in);
   assign use_clock_in = use_clock_ff + STAMP_W'(1);

   always_comb begin
      if (hit_found_ff || (fault_count_ff == COUNT_MAX)) begin
         fault_count_in = fault_count_ff;
      end else begin
         fault_count_in = fault_count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         chk_vld_ff     <= 1'b0;
         frame_valid_ff <= '0;
         use_clock_ff   <= '0;
         fault_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         chk_vld_ff <= (state_ff == ST_SCAN);
         chk_idx_ff <= cnt_ff;

         if (scan_hit) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= chk_idx_ff;
         end
         if (scan_free) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= chk_idx_ff;
         end
         if (scan_lower) begin
            lru_idx_ff   <= chk_idx_ff;
            lru_stamp_ff <= rd_stamp;
            lru_page_ff  <= rd_page;
         end

         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  page_ff       <= page_in;
                  hit_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_TAIL;
               end else begin
                  cnt_ff <= cnt_ff + IDX_W'(1);
               end
            end
            ST_TAIL: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (out_free) begin
                  use_clock_ff            <= use_clock_in;
                  fault_count_ff          <= fault_count_in;
                  frame_valid_ff[slot_in] <= 1'b1;
                  rsp_hit_ff              <= hit_found_ff;
                  rsp_slot_ff             <= slot_ext[SLOT_W-1:0];
                  rsp_evicted_ff          <= evict_in;
                  rsp_evicted_page_ff     <= evict_in ? lru_page_ext[PAGE_FIELD_W-1:0] : '0;
                  rsp_fault_total_ff      <= fault_count_in;
                  state_ff                <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evicted_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_total   = rsp_fault_total_ff;

endmodule

// ===== hdl/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module lrupr_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_hit,
   input  logic [lrupr_pkg::SLOT_W-1:0]         rsp_frame_slot,
   input  logic                                 rsp_evicted_valid,
   input  logic [lrupr_pkg::PAGE_FIELD_W-1:0]   rsp_evicted_page,
   input  logic [lrupr_pkg::COUNT_W-1:0]        rsp_fault_total
);
   import lrupr_pkg::*;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("core took a second transaction without scanning");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_slot)
                                    && $stable(rsp_fault_total)))
      else $error("stalled response changed");

   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_fault_total != '0))
      else $error("fault reported with zero fault total");

   a_evict_only_on_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted_valid) |-> !rsp_hit)
      else $error("eviction reported on a hit");

   a_no_evict_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_page == '0))
      else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_hit           (rsp_hit),
   .rsp_frame_slot    (rsp_frame_slot),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page),
   .rsp_fault_total   (rsp_fault_total)
);
